>>> sv/fscd_pkg.sv
// ----------------------------------------------------------------------------
// fscd_pkg
// Shared widths, constants and queue entry types of the coin detector.
// ----------------------------------------------------------------------------
package fscd_pkg;

   localparam int CLK_W   = 27;   // clock_hz
   localparam int CYC_W   = 10;   // cycles_per_measure
   localparam int TMO_W   = 41;   // timeout_ticks
   localparam int THR_W   = 20;   // threshold_ppm
   localparam int FREQ_W  = 26;   // frequency and average
   localparam int TICK_W  = TMO_W + 1;       // a tick count one past the timeout
   localparam int DVD_W   = CLK_W + CYC_W;   // clock_hz * cycles
   localparam int DEV_W   = FREQ_W + THR_W;  // ppm-scaled deviation
   localparam int CSR_W   = TMO_W;           // widest register
   localparam int CSR_IDX_W = 2;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [FREQ_W-1:0] FREQ_MAX  = {FREQ_W{1'b1}};
   localparam logic [THR_W-1:0]  PPM_SCALE = THR_W'(1000000);

   localparam logic [CLK_W-1:0] CLOCK_HZ_RST = CLK_W'(32000000);
   localparam logic [CYC_W-1:0] CYCLES_RST   = CYC_W'(100);
   localparam logic [TMO_W-1:0] TIMEOUT_RST  = TMO_W'(64'd1677721600000);
   localparam logic [THR_W-1:0] THRESH_RST   = THR_W'(5000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLOCK_HZ  = 2'd0,
      CSR_CYCLES    = 2'd1,
      CSR_TIMEOUT   = 2'd2,
      CSR_THRESHOLD = 2'd3
   } csr_idx_type;

   typedef enum logic {
      STATUS_DONE    = 1'b0,
      STATUS_TIMEOUT = 1'b1
   } status_type;

   // front to back: one finished measurement or one timeout
   typedef struct packed {
      logic              timeout;
      logic [TICK_W-1:0] ticks;
   } cmd_type;

   typedef struct packed {
      status_type        status;
      logic [FREQ_W-1:0] frequency_hz;
      logic [FREQ_W-1:0] average_hz;
      logic              coin_detected;
   } rsp_type;

endpackage

>>> sv/fscd_fifo.sv
// ----------------------------------------------------------------------------
// fscd_fifo
// Small show-ahead queue; the head entry is visible while valid is high.
// ----------------------------------------------------------------------------
module fscd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign valid   = (count_ff != '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/fscd_front.sv
// ----------------------------------------------------------------------------
// fscd_front
// Per-sample edge tracking, tick and cycle counting, timeout detection.
// ----------------------------------------------------------------------------
module fscd_front
   import fscd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             sample_valid,
   input  logic             signal_level,
   input  logic [CYC_W-1:0] cycles_per_measure,
   input  logic [TMO_W-1:0] timeout_ticks,
   output logic             cmd_push,
   output cmd_type          cmd_data
);

   typedef enum logic [3:0] {
      WAIT_LOW  = 4'b0001,
      WAIT_HIGH = 4'b0010,
      MEAS_LOW  = 4'b0100,
      MEAS_HIGH = 4'b1000
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [TMO_W-1:0]   tick_ff, tick_in;
   logic [CYC_W-1:0]   cycle_ff, cycle_in;
   logic [TICK_W-1:0]  next_tick;
   logic [CYC_W-1:0]   cyc;
   logic [CYC_W:0]     cycle_inc;
   logic               done;

   assign cyc       = (cycles_per_measure == '0) ? CYC_W'(1) : cycles_per_measure;
   assign next_tick = TICK_W'(tick_ff) + 1'b1;
   assign cycle_inc = (CYC_W + 1)'(cycle_ff) + 1'b1;

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      cycle_in = cycle_ff;
      cmd_push = 1'b0;
      cmd_data.timeout = 1'b0;
      cmd_data.ticks   = next_tick;
      done     = 1'b0;
      if (sample_valid) begin
         unique case (phase_ff)
            WAIT_LOW: begin
               if (!signal_level) begin
                  phase_in = WAIT_HIGH;
                  tick_in  = '0;
                  done     = 1'b1;
               end
            end
            WAIT_HIGH: begin
               if (signal_level) begin
                  phase_in = MEAS_LOW;
                  tick_in  = '0;
                  cycle_in = '0;
                  done     = 1'b1;
               end
            end
            MEAS_LOW: begin
               if (!signal_level) begin
                  phase_in = MEAS_HIGH;
               end
            end
            MEAS_HIGH: begin
               if (signal_level) begin
                  cycle_in = cycle_inc[CYC_W-1:0];
                  phase_in = MEAS_LOW;
                  if (cycle_inc >= (CYC_W + 1)'(cyc)) begin
                     // last rising edge closes the measurement
                     cmd_push = 1'b1;
                     phase_in = WAIT_LOW;
                     tick_in  = '0;
                     cycle_in = '0;
                     done     = 1'b1;
                  end
               end
            end
            default: begin
               phase_in = WAIT_LOW;
            end
         endcase
         if (!done) begin
            if (next_tick > TICK_W'(timeout_ticks)) begin
               cmd_push = 1'b1;
               cmd_data.timeout = 1'b1;
               phase_in = WAIT_LOW;
               tick_in  = '0;
               cycle_in = '0;
            end else begin
               tick_in = next_tick[TMO_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= WAIT_LOW;
         tick_ff  <= '0;
         cycle_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         cycle_ff <= cycle_in;
      end
   end

endmodule

>>> sv/fscd_div.sv
// ----------------------------------------------------------------------------
// fscd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fscd_div
   import fscd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DVD_W-1:0]  dividend,
   input  logic [TICK_W-1:0] divisor,
   output logic              done,
   output logic [DVD_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [TICK_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [TICK_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [TICK_W:0]   shifted;
   logic [TICK_W:0]   diff;
   logic              fits;

   assign shifted  = {rem_ff, quo_ff[DVD_W-1]};
   assign diff     = shifted - {1'b0, dvs_ff};
   assign fits     = (shifted >= {1'b0, dvs_ff});
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
         cnt_in = CNT_W'(DVD_W);
      end else if (cnt_ff != '0) begin
         // remainder stays below the divisor, so the top bit drops off
         rem_in  = fits ? diff[TICK_W-1:0] : shifted[TICK_W-1:0];
         quo_in  = {quo_ff[DVD_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

endmodule

>>> sv/fscd_back.sv
// ----------------------------------------------------------------------------
// fscd_back
// Turns tick counts into frequency, keeps the averaging ring and baseline,
// and decides on a coin; timeouts pass straight through as timeout results.
// ----------------------------------------------------------------------------
module fscd_back
   import fscd_pkg::*;
#(
   parameter int AVG_DEPTH = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  cmd_type          cmd_data,
   output logic             cmd_pop,
   input  logic             out_full,
   output logic             out_push,
   output rsp_type          out_data,
   input  logic [CLK_W-1:0] clock_hz,
   input  logic [CYC_W-1:0] cycles_per_measure,
   input  logic [THR_W-1:0] threshold_ppm
);

   localparam int IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
   localparam int SUM_W = FREQ_W + $clog2(AVG_DEPTH + 1);

   // average = (sum * ceil(2^AVG_SHIFT / AVG_DEPTH)) >> AVG_SHIFT, exact for
   // every sum below 2^SUM_W
   localparam int AVG_SHIFT = SUM_W + $clog2(AVG_DEPTH);
   localparam int RCP_W     = SUM_W + 1;
   localparam int PROD_W    = SUM_W + RCP_W;
   localparam logic [RCP_W-1:0] AVG_RECIP =
      RCP_W'(((64'd1 << AVG_SHIFT) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_MUL  = 8'b0000_0010,
      ST_DIVF = 8'b0000_0100,
      ST_RING = 8'b0000_1000,
      ST_DIVA = 8'b0001_0000,
      ST_DIFF = 8'b0010_0000,
      ST_MULC = 8'b0100_0000,
      ST_PUSH = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [FREQ_W-1:0]  ring_ff [AVG_DEPTH];
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [FREQ_W-1:0]  base_ff, base_in;
   logic               ring_we;

   logic [TICK_W-1:0]  ticks_ff;
   logic [FREQ_W-1:0]  freq_ff;
   logic [FREQ_W-1:0]  avg_ff;
   logic [FREQ_W-1:0]  diff_ff;
   logic [DEV_W-1:0]   dev_ff;
   logic [DEV_W-1:0]   lim_ff;

   logic               div_start;
   logic [DVD_W-1:0]   div_dividend;
   logic [TICK_W-1:0]  div_divisor;
   logic               div_done;
   logic [DVD_W-1:0]   div_quotient;
   logic [CYC_W-1:0]   cyc;
   logic [DVD_W-1:0]   product;
   logic [PROD_W-1:0]  avg_prod;

   assign cyc      = (cycles_per_measure == '0) ? CYC_W'(1) : cycles_per_measure;
   assign product  = DVD_W'(clock_hz) * DVD_W'(cyc);
   assign avg_prod = PROD_W'(sum_ff) * PROD_W'(AVG_RECIP);

   fscd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      base_in      = base_ff;
      ring_we      = 1'b0;
      cmd_pop      = 1'b0;
      out_push     = 1'b0;
      out_data.status        = STATUS_DONE;
      out_data.frequency_hz  = freq_ff;
      out_data.average_hz    = avg_ff;
      out_data.coin_detected = (dev_ff > lim_ff);
      div_start    = 1'b0;
      div_dividend = product;
      div_divisor  = ticks_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && !out_full) begin
               cmd_pop = 1'b1;
               if (cmd_data.timeout) begin
                  out_push = 1'b1;
                  out_data.status        = STATUS_TIMEOUT;
                  out_data.frequency_hz  = '0;
                  out_data.average_hz    = '0;
                  out_data.coin_detected = 1'b0;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            div_start = 1'b1;
            state_in  = ST_DIVF;
         end
         ST_DIVF: begin
            if (div_done) begin
               state_in = ST_RING;
            end
         end
         ST_RING: begin
            // running sum replaces the overwritten entry
            ring_we   = 1'b1;
            sum_in    = sum_ff - SUM_W'(ring_ff[idx_ff]) + SUM_W'(freq_ff);
            idx_in    = (idx_ff == IDX_W'(AVG_DEPTH - 1)) ? '0 : idx_ff + 1'b1;
            if (base_ff == '0) begin
               base_in = freq_ff;
            end
            state_in  = ST_DIVA;
         end
         ST_DIVA: begin
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            state_in = ST_MULC;
         end
         ST_MULC: begin
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            out_push = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         sum_ff   <= '0;
         base_ff  <= '0;
         for (int i = 0; i < AVG_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         sum_ff   <= sum_in;
         base_ff  <= base_in;
         if (ring_we) begin
            ring_ff[idx_ff] <= freq_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && cmd_valid && !out_full) begin
         ticks_ff <= cmd_data.ticks;
      end
      if (state_ff == ST_DIVF && div_done) begin
         freq_ff <= (div_quotient > DVD_W'(FREQ_MAX)) ? FREQ_MAX
                                                     : div_quotient[FREQ_W-1:0];
      end
      if (state_ff == ST_DIVA) begin
         avg_ff <= avg_prod[AVG_SHIFT +: FREQ_W];
      end
      if (state_ff == ST_DIFF) begin
         diff_ff <= (avg_ff > base_ff) ? avg_ff - base_ff : base_ff - avg_ff;
      end
      if (state_ff == ST_MULC) begin
         dev_ff <= DEV_W'(diff_ff) * DEV_W'(PPM_SCALE);
         lim_ff <= DEV_W'(base_ff) * DEV_W'(threshold_ppm);
      end
   end

endmodule

>>> sv/frequency_shift_coin_detector.sv
// ----------------------------------------------------------------------------
// frequency_shift_coin_detector
// Reciprocal frequency counter with moving average and baseline deviation
// check for coin detection.
// ----------------------------------------------------------------------------
//  channel  ports                        moves
//  req      req_push / req_full          one pin sample per request
//  rsp      rsp_pop / rsp_empty          one result per measurement or timeout
//  csr      csr_wr_en, csr_index, wdata  register write, no wait
//
//  The front takes one sample per cycle while req_full is low.
//  A finished measurement holds the back through the multiply, one pass
//  of the bit-serial divider (37 quotient bits), ring, averaging and push;
//  a timeout is pushed from idle. Two finished measurements or timeouts
//  queue between front and back; req_full rises when that queue is full,
//  rsp results wait in a two-entry queue.
//  Synchronous reset clears counters, ring, baseline; CSRs take defaults.
// ----------------------------------------------------------------------------
module frequency_shift_coin_detector
   import fscd_pkg::*;
#(
   parameter int AVG_DEPTH = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic                 req_signal_level,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic                 rsp_status,
   output logic [FREQ_W-1:0]    rsp_frequency_hz,
   output logic [FREQ_W-1:0]    rsp_average_hz,
   output logic                 rsp_coin_detected,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   logic [CLK_W-1:0] clock_hz_ff;
   logic [CYC_W-1:0] cycles_ff;
   logic [TMO_W-1:0] timeout_ff;
   logic [THR_W-1:0] thresh_ff;

   logic      sample_valid;
   logic      cmd_push, cmd_full, cmd_valid, cmd_pop;
   cmd_type   cmd_in, cmd_head;
   logic      out_push, out_full, out_valid;
   rsp_type   out_in, out_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= CLOCK_HZ_RST;
         cycles_ff   <= CYCLES_RST;
         timeout_ff  <= TIMEOUT_RST;
         thresh_ff   <= THRESH_RST;
      end else if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_CLOCK_HZ:  clock_hz_ff <= csr_wdata[CLK_W-1:0];
            CSR_CYCLES:    cycles_ff   <= csr_wdata[CYC_W-1:0];
            CSR_TIMEOUT:   timeout_ff  <= csr_wdata[TMO_W-1:0];
            CSR_THRESHOLD: thresh_ff   <= csr_wdata[THR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_full     = cmd_full;
   assign sample_valid = req_push && !cmd_full;

   fscd_front u_front (
      .clock              (clock),
      .reset              (reset),
      .sample_valid       (sample_valid),
      .signal_level       (req_signal_level),
      .cycles_per_measure (cycles_ff),
      .timeout_ticks      (timeout_ff),
      .cmd_push           (cmd_push),
      .cmd_data           (cmd_in)
   );

   fscd_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .valid     (cmd_valid),
      .head      (cmd_head)
   );

   fscd_back #(
      .AVG_DEPTH (AVG_DEPTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (cmd_valid),
      .cmd_data           (cmd_head),
      .cmd_pop            (cmd_pop),
      .out_full           (out_full),
      .out_push           (out_push),
      .out_data           (out_in),
      .clock_hz           (clock_hz_ff),
      .cycles_per_measure (cycles_ff),
      .threshold_ppm      (thresh_ff)
   );

   fscd_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_in),
      .full      (out_full),
      .pop       (rsp_pop),
      .valid     (out_valid),
      .head      (out_head)
   );

   assign rsp_empty         = !out_valid;
   assign rsp_status        = out_head.status;
   assign rsp_frequency_hz  = out_head.frequency_hz;
   assign rsp_average_hz    = out_head.average_hz;
   assign rsp_coin_detected = out_head.coin_detected;

endmodule
